[rtl/core/blpd_pkg.sv]
// ----------------------------------------------------------------------------
// blpd_pkg
// shared widths, command codes and status codes of the bounded list block
// ----------------------------------------------------------------------------
package blpd_pkg;

  // field widths
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // default list capacity
  localparam int DEPTH_DEFAULT = 64;

  // command codes
  localparam logic [ACTION_W-1:0] ACT_APPEND    = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DEL_FIRST = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DEL_LAST  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DEL_POS   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DEL_MID   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

endpackage

[rtl/core/blpd_ram.sv]
// ----------------------------------------------------------------------------
// blpd_ram
// entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module blpd_ram #(
  parameter int DEPTH = blpd_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(blpd_pkg::DEPTH_DEFAULT)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               wr_addr,
  input  logic [blpd_pkg::VALUE_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [blpd_pkg::VALUE_W-1:0] rd_data
);
  import blpd_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/bounded_list_positional_delete.sv]
// ----------------------------------------------------------------------------
// bounded_list_positional_delete
// packed ordered list of signed values in one memory, with append and
// removal of the first, last, positional or middle entry plus compaction
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake        payload
//  -------  ---------  ---------------  ----------------------------------
//  in       sink       in_valid/stall   action, value, position
//  out      source     out_valid/stall  status, removed_value, entry_count
//
//  append and every rejected command: accept, then S_FINISH, then the
//    output register; a successful removal at 0-based index idx passes
//    S_TAKE, S_SHIFT for each entry above idx, then S_FINISH; the single
//    memory port pair moves one entry down per cycle during compaction
//  reset clears the entry count, the sequencer state and out_valid; the memory is never cleared
//  a finished result waits in the output register while the next item
//    is taken and worked on; in_stall is high while an item is in work
//
module bounded_list_positional_delete #(
  parameter int DEPTH = blpd_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [blpd_pkg::ACTION_W-1:0]       action,
  input  logic signed [blpd_pkg::VALUE_W-1:0] value,
  input  logic [blpd_pkg::POS_W-1:0]          position,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [blpd_pkg::STATUS_W-1:0]       status,
  output logic signed [blpd_pkg::VALUE_W-1:0] removed_value,
  output logic [blpd_pkg::COUNT_W-1:0]        entry_count
);
  import blpd_pkg::*;

  // address, length and compare widths
  localparam int AW  = $clog2(DEPTH);
  localparam int LW  = $clog2(DEPTH + 1);
  localparam int CW0 = (LW > POS_W) ? LW : POS_W;
  localparam int CW  = (CW0 > COUNT_W) ? CW0 : COUNT_W;

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_TAKE   = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]          state;
  logic [LW-1:0]       length;     // entry count, already updated at accept
  logic [LW-1:0]       ptr;        // next address to read while compacting
  logic [AW-1:0]       wa;         // next address to write while compacting
  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0]  res_removed;
  logic [COUNT_W-1:0]  res_count;

  // memory ports
  logic               mem_we;
  logic [AW-1:0]      mem_wr_addr;
  logic [VALUE_W-1:0] mem_wr_data;
  logic [AW-1:0]      mem_rd_addr;
  logic [VALUE_W-1:0] mem_rd_data;

  // command decode
  logic                accept;
  logic                is_full;
  logic                is_empty;
  logic [CW-1:0]       len_ext;
  logic [CW-1:0]       pos_ext;
  logic [CW-1:0]       idx_c;
  logic [CW-1:0]       new_len;
  logic [STATUS_W-1:0] cmd_status;
  logic                del_go;
  logic                out_free;
  logic                more;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign is_full  = (length == LW'(DEPTH));
  assign is_empty = (length == '0);
  assign len_ext  = CW'(length);
  assign pos_ext  = CW'(position);
  // another entry still above the write point
  assign more     = (ptr <= length);

  always_comb begin
    cmd_status = STAT_OK;
    del_go     = 1'b0;
    idx_c      = '0;
    new_len    = len_ext;
    unique case (action)
      ACT_APPEND: begin
        if (is_full) begin
          cmd_status = STAT_FULL;
        end else begin
          new_len = len_ext + CW'(1);
        end
      end
      ACT_DEL_FIRST: begin
        if (is_empty) begin
          cmd_status = STAT_EMPTY;
        end else begin
          del_go = 1'b1;
        end
      end
      ACT_DEL_LAST: begin
        if (is_empty) begin
          cmd_status = STAT_EMPTY;
        end else begin
          del_go = 1'b1;
          idx_c  = len_ext - CW'(1);
        end
      end
      ACT_DEL_POS: begin
        // empty list is reported before a bad position
        if (is_empty) begin
          cmd_status = STAT_EMPTY;
        end else if (pos_ext == '0 || pos_ext > len_ext) begin
          cmd_status = STAT_NOT_FOUND;
        end else begin
          del_go = 1'b1;
          idx_c  = pos_ext - CW'(1);
        end
      end
      ACT_DEL_MID: begin
        if (is_empty) begin
          cmd_status = STAT_EMPTY;
        end else begin
          del_go = 1'b1;
          idx_c  = len_ext >> 1;
        end
      end
      default: begin
        // unused codes leave the list alone and report ok
      end
    endcase
    if (del_go) begin
      new_len = len_ext - CW'(1);
    end
  end

  // memory port steering: append writes the tail, compaction writes down
  always_comb begin
    mem_we      = 1'b0;
    mem_wr_addr = wa;
    mem_wr_data = mem_rd_data;
    mem_rd_addr = ptr[AW-1:0];
    if (state == S_IDLE) begin
      // the removed entry is read in the cycle of accept
      mem_rd_addr = idx_c[AW-1:0];
      if (accept && action == ACT_APPEND && !is_full) begin
        mem_we      = 1'b1;
        mem_wr_addr = length[AW-1:0];
        mem_wr_data = value;
      end
    end else if (state == S_SHIFT) begin
      mem_we = 1'b1;
    end
  end

  blpd_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // sequencer and result holding registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      length <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            length      <= new_len[LW-1:0];
            res_status  <= cmd_status;
            res_removed <= '0;
            res_count   <= new_len[COUNT_W-1:0];
            ptr         <= idx_c[LW-1:0] + LW'(1);
            wa          <= idx_c[AW-1:0];
            state       <= del_go ? S_TAKE : S_FINISH;
          end
        end
        S_TAKE: begin
          // read data now holds the removed entry
          res_removed <= mem_rd_data;
          if (more) begin
            ptr   <= ptr + LW'(1);
            state <= S_SHIFT;
          end else begin
            state <= S_FINISH;
          end
        end
        S_SHIFT: begin
          wa <= wa + AW'(1);
          if (more) begin
            ptr <= ptr + LW'(1);
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid     <= 1'b1;
      status        <= res_status;
      removed_value <= res_removed;
      entry_count   <= res_count;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // count never passes capacity
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LW'(DEPTH))
    else $error("entry count above capacity");

  // compaction always writes below the entry it reads next
  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (LW'(wa) < ptr))
    else $error("compaction write overtook read");

  // an accepted append into a list with room grows it by one
  a_append_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_APPEND && !is_full) |=> (length == $past(length) + LW'(1)))
    else $error("append did not grow the list");

  // a result is only loaded after the sequencer has finished
  a_load_from_finish: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid)) |-> ($past(state) == S_FINISH))
    else $error("result loaded outside finish");

endmodule
